### design/evst_pkg.sv
// shared types and constants of the event slot table
package evst_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int KIND_W         = 3;
  localparam int CLASS_W        = 32;
  localparam int SPEC_W         = 32;
  localparam int MODE_W         = 16;
  localparam int HANDLE_W       = 8;
  localparam int NEW_HANDLE_W   = 5;
  localparam int FIRED_W        = 16;

  localparam logic [MODE_W-1:0] MASK_RESET = 16'h1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN      = 3'd0,
    KIND_CLOSE     = 3'd1,
    KIND_TEST      = 3'd2,
    KIND_DELIVER   = 3'd3,
    KIND_UNDELIVER = 3'd4
  } kind_t;

  // one registered operation toward the slot table
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [CLASS_W-1:0]  event_class;
    logic [SPEC_W-1:0]   event_spec;
    logic [MODE_W-1:0]   event_mode;
    logic                has_callback;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  // answer of the slot table for that operation
  typedef struct packed {
    logic [NEW_HANDLE_W-1:0] new_handle;
    logic                    table_full;
    logic                    test_hit;
    logic [FIRED_W-1:0]      fired_mask;
  } rsp_t;

endpackage

### design/event_slot_table_unit.sv
// top level of the event slot table: input register, slot table, result register
//
//   channel   ports                                   flow control
//   input     start, busy, in_*                       transfer when start && !busy
//   result    out_valid, out_*                        one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_wdata                       write when cfg_we, no wait
//
// one transfer per cycle is sustained while busy is low; the result of a
// transfer goes through the input register, then takes one pass through the
// slot table into the result register
// the slot table update lands at the same edge that captures the next item,
// so back-to-back items always see the updated table
// synchronous reset clears all slot marks and the mode mask goes to 0x1000;
// busy is set during reset and clears at the first clock edge that samples rst_n high
// the receiver cannot stall, so busy never rises during normal operation
module event_slot_table_unit
  import evst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [CLASS_W-1:0]      in_event_class,
  input  logic [SPEC_W-1:0]       in_event_spec,
  input  logic [MODE_W-1:0]       in_event_mode,
  input  logic                    in_has_callback,
  input  logic [HANDLE_W-1:0]     in_handle,
  // result channel
  output logic                    out_valid,
  output logic [NEW_HANDLE_W-1:0] out_new_handle,
  output logic                    out_table_full,
  output logic                    out_test_hit,
  output logic [FIRED_W-1:0]      out_fired_mask,
  // configuration
  input  logic                    cfg_we,
  input  logic [MODE_W-1:0]       cfg_wdata
);

  logic        busy_r;
  logic [MODE_W-1:0] mask_r;
  req_t        req_r, req_nxt;
  rsp_t        rsp;
  logic        out_valid_r;
  rsp_t        rsp_r;

  // busy only covers the reset window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // interrupt mode mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // input register: capture the item on a transfer
  always_comb begin
    req_nxt.valid        = start && !busy_r;
    req_nxt.kind         = in_kind;
    req_nxt.event_class  = in_event_class;
    req_nxt.event_spec   = in_event_spec;
    req_nxt.event_mode   = in_event_mode;
    req_nxt.has_callback = in_has_callback;
    req_nxt.handle       = in_handle;
  end

  // only the valid flag is reset, the payload half needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r.valid <= req_nxt.valid;
    end
    req_r.kind         <= req_nxt.kind;
    req_r.event_class  <= req_nxt.event_class;
    req_r.event_spec   <= req_nxt.event_spec;
    req_r.event_mode   <= req_nxt.event_mode;
    req_r.has_callback <= req_nxt.has_callback;
    req_r.handle       <= req_nxt.handle;
  end

  // one pass through the table: match, free search and state update
  evst_slots #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .irq_mask (mask_r),
    .rsp      (rsp)
  );

  // result register, strobed for one cycle per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp;
  end

  assign out_valid      = out_valid_r;
  assign out_new_handle = rsp_r.new_handle;
  assign out_table_full = rsp_r.table_full;
  assign out_test_hit   = rsp_r.test_hit;
  assign out_fired_mask = rsp_r.fired_mask;

endmodule

### design/evst_slots.sv
// slot storage with parallel match, free-slot search and state update
module evst_slots
  import evst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  req_t              req,
  input  logic [MODE_W-1:0] irq_mask,
  output rsp_t              rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [HANDLE_W:0] SLOT_LIMIT = (HANDLE_W+1)'(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0] pend_r, pend_nxt;
  logic [SLOT_COUNT-1:0] cb_r, cb_nxt;
  logic [CLASS_W-1:0]    class_r [SLOT_COUNT];
  logic [SPEC_W-1:0]     spec_r  [SLOT_COUNT];
  logic [MODE_W-1:0]     mode_r  [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] fire;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W:0]        handle_full;
  logic                  in_range;
  logic [HANDLE_W-1:0]   handle_m1;
  logic [IDX_W-1:0]      idx;
  logic                  wr_open;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = used_r[i] && (class_r[i] == req.event_class) &&
                 (spec_r[i] == req.event_spec);
      fire[i]  = match[i] && (|(mode_r[i] & irq_mask)) && cb_r[i];
    end
  end

  // lowest free slot
  always_comb begin
    free_found = ~&used_r;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign handle_full = (IDX_W+1)'(free_idx) + 1'b1;
  assign in_range    = (req.handle != '0) && ({1'b0, req.handle} <= SLOT_LIMIT);
  assign handle_m1   = req.handle - 1'b1;
  assign idx         = handle_m1[IDX_W-1:0];

  always_comb begin
    used_nxt = used_r;
    pend_nxt = pend_r;
    cb_nxt   = cb_r;
    wr_open  = 1'b0;
    rsp      = '0;
    if (req.valid) begin
      unique case (kind_t'(req.kind))
        KIND_OPEN: begin
          if (free_found) begin
            used_nxt[free_idx] = 1'b1;
            pend_nxt[free_idx] = 1'b0;
            cb_nxt[free_idx]   = req.has_callback;
            wr_open            = 1'b1;
            rsp.new_handle     = NEW_HANDLE_W'(handle_full);
          end else begin
            rsp.table_full = 1'b1;
          end
        end
        KIND_CLOSE: begin
          if (in_range) begin
            used_nxt[idx] = 1'b0;
            cb_nxt[idx]   = 1'b0;
          end
        end
        KIND_TEST: begin
          if (in_range && used_r[idx] && pend_r[idx]) begin
            pend_nxt[idx] = 1'b0;
            rsp.test_hit  = 1'b1;
          end
        end
        KIND_DELIVER: begin
          pend_nxt       = pend_r | match;
          rsp.fired_mask = FIRED_W'(fire);
        end
        KIND_UNDELIVER: begin
          pend_nxt = pend_r & ~match;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      pend_r <= '0;
      cb_r   <= '0;
    end else begin
      used_r <= used_nxt;
      pend_r <= pend_nxt;
      cb_r   <= cb_nxt;
    end
  end

  // slot payload, written only by open
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (wr_open && (free_idx == IDX_W'(i))) begin
        class_r[i] <= req.event_class;
        spec_r[i]  <= req.event_spec;
        mode_r[i]  <= req.event_mode;
      end
    end
  end

endmodule

### design/evst_checker.sv
// port-level checks of the event slot table and their bind
module evst_checker
  import evst_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [NEW_HANDLE_W-1:0] out_new_handle,
  input logic                    out_table_full,
  input logic                    out_test_hit,
  input logic [FIRED_W-1:0]      out_fired_mask
);

  // every transfer is followed by a result strobe on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, 2) && !$past(busy, 2)))
    else $error("result without a matching transfer");

  // open results, test results and deliver results never mix
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({(out_new_handle != '0) || out_table_full,
                            out_test_hit, out_fired_mask != '0}))
    else $error("result fields of different operations set together");

  a_full_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_new_handle == '0))
    else $error("handle given while table full");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

endmodule

bind event_slot_table_unit evst_checker u_evst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_new_handle (out_new_handle),
  .out_table_full (out_table_full),
  .out_test_hit   (out_test_hit),
  .out_fired_mask (out_fired_mask)
);

### tb/tb_event_slot_table_unit.sv
// self-checking testbench of the event slot table unit: directed and random transfers
module tb_event_slot_table_unit
  import evst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = SLOT_COUNT_DEF;
  localparam int CYCLE_CAP  = 200000;   // far above the slowest legal run
  localparam int DRAIN_WAIT = 8;        // margin for the last result to land after the final transfer

  // kinds outside the defined set, the block must leave the table alone
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  // one operation as the sender presents it
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [CLASS_W-1:0]  event_class;
    logic [SPEC_W-1:0]   event_spec;
    logic [MODE_W-1:0]   event_mode;
    logic                has_callback;
    logic [HANDLE_W-1:0] handle;
  } slot_op_t;

  // block ports, all inputs known from time zero
  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic [KIND_W-1:0]       in_kind         = '0;
  logic [CLASS_W-1:0]      in_event_class  = '0;
  logic [SPEC_W-1:0]       in_event_spec   = '0;
  logic [MODE_W-1:0]       in_event_mode   = '0;
  logic                    in_has_callback = 1'b0;
  logic [HANDLE_W-1:0]     in_handle       = '0;
  logic                    out_valid;
  logic [NEW_HANDLE_W-1:0] out_new_handle;
  logic                    out_table_full;
  logic                    out_test_hit;
  logic [FIRED_W-1:0]      out_fired_mask;
  logic                    cfg_we          = 1'b0;
  logic [MODE_W-1:0]       cfg_wdata       = '0;

  // shadow copy of the slot table and the mode mask
  logic              shadow_used     [SLOTS];
  logic              shadow_pending  [SLOTS];
  logic [CLASS_W-1:0] shadow_class   [SLOTS];
  logic [SPEC_W-1:0] shadow_spec     [SLOTS];
  logic [MODE_W-1:0] shadow_mode     [SLOTS];
  logic              shadow_callback [SLOTS];
  logic [MODE_W-1:0] shadow_irq_mask = MASK_RESET;

  slot_op_t pending_op_q[$];     // operations not yet handed to the block
  rsp_t     table_answer_q[$];   // answers owed by the block, oldest first

  // class and spec pools so that delivers actually hit open slots
  logic [CLASS_W-1:0] class_pool [4];
  logic [SPEC_W-1:0]  spec_pool  [4];

  slot_op_t op_on_port;
  bit       op_held      = 1'b0;  // an operation sits on the input ports
  bit       just_taken   = 1'b0;  // a transfer happened at the last rising edge
  bit       idle_enable  = 1'b1;
  int       gap_left     = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;

  event_slot_table_unit #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_event_class (in_event_class),
    .in_event_spec  (in_event_spec),
    .in_event_mode  (in_event_mode),
    .in_has_callback(in_has_callback),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_new_handle (out_new_handle),
    .out_table_full (out_table_full),
    .out_test_hit   (out_test_hit),
    .out_fired_mask (out_fired_mask),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // apply one operation to the shadow table and work out the block's answer
  function automatic rsp_t apply_table_op(input slot_op_t op);
    rsp_t ans;
    bit   in_range;
    bit   claimed;
    int   idx;
    ans      = '0;
    in_range = (op.handle >= 1) && (op.handle <= SLOTS);
    idx      = in_range ? int'(op.handle) - 1 : 0;
    claimed  = 1'b0;
    case (op.kind)
      KIND_OPEN: begin
        // lowest free slot wins, the table is full when none is free
        ans.table_full = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!claimed && !shadow_used[i]) begin
            claimed            = 1'b1;
            shadow_used[i]     = 1'b1;
            shadow_pending[i]  = 1'b0;
            shadow_class[i]    = op.event_class;
            shadow_spec[i]     = op.event_spec;
            shadow_mode[i]     = op.event_mode;
            shadow_callback[i] = op.has_callback;
            ans.new_handle     = NEW_HANDLE_W'(i + 1);
            ans.table_full     = 1'b0;
          end
        end
      end
      KIND_CLOSE: begin
        // pending stays as it is, only used and callback drop
        if (in_range) begin
          shadow_used[idx]     = 1'b0;
          shadow_callback[idx] = 1'b0;
        end
      end
      KIND_TEST: begin
        if (in_range && shadow_used[idx] && shadow_pending[idx]) begin
          shadow_pending[idx] = 1'b0;
          ans.test_hit        = 1'b1;
        end
      end
      KIND_DELIVER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && shadow_class[i] == op.event_class &&
              shadow_spec[i] == op.event_spec) begin
            shadow_pending[i] = 1'b1;
            if ((shadow_mode[i] & shadow_irq_mask) != '0 && shadow_callback[i] &&
                i < FIRED_W) begin
              ans.fired_mask[i] = 1'b1;
            end
          end
        end
      end
      KIND_UNDELIVER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && shadow_class[i] == op.event_class &&
              shadow_spec[i] == op.event_spec) begin
            shadow_pending[i] = 1'b0;
          end
        end
      end
      default: begin
        // spare kinds: no change, all fields zero
      end
    endcase
    return ans;
  endfunction

  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [CLASS_W-1:0] cls,
                          input logic [SPEC_W-1:0] spec, input logic [MODE_W-1:0] mode,
                          input logic cb, input logic [HANDLE_W-1:0] handle);
    slot_op_t op;
    op.kind         = kind;
    op.event_class  = cls;
    op.event_spec   = spec;
    op.event_mode   = mode;
    op.has_callback = cb;
    op.handle       = handle;
    pending_op_q.push_back(op);
  endtask

  // new class/spec pools per phase, both extremes in each
  task automatic refresh_pools();
    class_pool[0] = '0;
    class_pool[1] = '1;
    spec_pool[0]  = '1;
    spec_pool[1]  = '0;
    for (int i = 2; i < 4; i++) begin
      class_pool[i] = $urandom;
      spec_pool[i]  = $urandom;
    end
  endtask

  // random operation, open and close weights in percent steer the fill level
  task automatic queue_random_op(input int open_w, input int close_w);
    int                  bucket;
    int                  sub;
    logic [KIND_W-1:0]   kind;
    logic [CLASS_W-1:0]  cls;
    logic [SPEC_W-1:0]   spec;
    logic [HANDLE_W-1:0] handle;
    bucket = $urandom_range(0, 99);
    sub    = $urandom_range(0, 19);
    if (bucket < open_w) begin
      kind = KIND_OPEN;
    end else if (bucket < open_w + close_w) begin
      kind = KIND_CLOSE;
    end else if (sub < 8) begin
      kind = KIND_DELIVER;
    end else if (sub < 14) begin
      kind = KIND_TEST;
    end else if (sub < 18) begin
      kind = KIND_UNDELIVER;
    end else begin
      kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    // mostly pooled keys so deliver and undeliver find their slots
    cls    = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom) : class_pool[$urandom_range(0, 3)];
    spec   = ($urandom_range(0, 9) == 0) ? SPEC_W'($urandom) : spec_pool[$urandom_range(0, 1)];
    // a few handles out of range, the rest hit real slots
    handle = ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom_range(0, 255))
                                         : HANDLE_W'($urandom_range(1, SLOTS));
    queue_op(kind, cls, spec, MODE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
             handle);
  endtask

  // block idle: nothing waiting, nothing on the ports, every answer in
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_op_q.size() != 0 || op_held || table_answer_q.size() != 0);
  endtask

  task automatic write_irq_mask(input logic [MODE_W-1:0] value);
    @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_wdata       <= value;
    shadow_irq_mask  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain, reprogram the mask, then queue a batch of random transfers
  task automatic run_phase(input logic [MODE_W-1:0] mask, input int lead_opens,
                           input int open_w, input int close_w, input int count,
                           input bit idle);
    wait_drained();
    write_irq_mask(mask);
    idle_enable = idle;
    refresh_pools();
    for (int i = 0; i < lead_opens; i++) begin
      queue_op(KIND_OPEN, class_pool[$urandom_range(0, 3)], spec_pool[$urandom_range(0, 1)],
               MODE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
               HANDLE_W'($urandom_range(0, 255)));
    end
    for (int i = 0; i < count; i++) begin
      queue_random_op(open_w, close_w);
    end
  endtask

  // sender: new values at the falling edge, held until the block takes them
  always @(negedge clk) begin
    if (just_taken) begin
      just_taken = 1'b0;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 11);
      end
    end
    if (!op_held) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_op_q.size() != 0) begin
        op_on_port       = pending_op_q.pop_front();
        op_held          = 1'b1;
        start           <= 1'b1;
        in_kind         <= op_on_port.kind;
        in_event_class  <= op_on_port.event_class;
        in_event_spec   <= op_on_port.event_spec;
        in_event_mode   <= op_on_port.event_mode;
        in_has_callback <= op_on_port.has_callback;
        in_handle       <= op_on_port.handle;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // transfer detection: predict the answer the moment the block takes an item
  always @(posedge clk) begin
    if (rst_n && start && !busy && op_held) begin
      table_answer_q.push_back(apply_table_op(op_on_port));
      op_held    = 1'b0;
      just_taken = 1'b1;
    end
  end

  // receiver: every strobe must match the oldest owed answer
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid) begin
      if (table_answer_q.size() == 0) begin
        report_mismatch("result strobe with no transfer outstanding");
      end else begin
        want = table_answer_q.pop_front();
        check_field("new_handle", 32'(out_new_handle), 32'(want.new_handle));
        check_field("table_full", 32'(out_table_full), 32'(want.table_full));
        check_field("test_hit", 32'(out_test_hit), 32'(want.test_hit));
        check_field("fired_mask", 32'(out_fired_mask), 32'(want.fired_mask));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_used[i]     = 1'b0;
      shadow_pending[i]  = 1'b0;
      shadow_class[i]    = '0;
      shadow_spec[i]     = '0;
      shadow_mode[i]     = '0;
      shadow_callback[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset mask (bit 12)
    queue_op(KIND_OPEN, '0, '0, '0, 1'b0, 8'd0);                      // all-zero fields
    queue_op(KIND_OPEN, '1, '1, '1, 1'b1, 8'd255);                    // all-one fields
    queue_op(KIND_OPEN, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h1000, 1'b1, 8'd3);
    queue_op(KIND_DELIVER, '0, '0, '0, 1'b0, 8'd0);                   // match, mode 0 never fires
    queue_op(KIND_DELIVER, '1, '1, '0, 1'b0, 8'd0);                   // fires slot 2
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd1);                      // hit and clear
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd1);                      // already cleared
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd0);                      // handle zero
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd17);                     // just past the table
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd255);
    queue_op(KIND_CLOSE, '0, '0, '0, 1'b0, 8'd0);                     // out of range, no effect
    queue_op(KIND_CLOSE, '0, '0, '0, 1'b0, 8'd255);
    queue_op(KIND_DELIVER, 32'hA5A5_A5A5, 32'h5A5A_5A5B, '0, 1'b0, 8'd0); // spec differs
    queue_op(KIND_DELIVER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, 1'b0, 8'd0);
    queue_op(KIND_UNDELIVER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0, 1'b0, 8'd0);
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd3);                      // undeliver cleared it
    queue_op(KIND_CLOSE, '0, '0, '0, 1'b0, 8'd2);                     // close keeps pending
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd2);                      // never hits a free slot
    queue_op(KIND_OPEN, 32'h0000_0001, 32'h8000_0000, 16'hEFFF, 1'b1, 8'd0); // reuses slot 2
    queue_op(KIND_TEST, '0, '0, '0, 1'b0, 8'd2);                      // open cleared pending
    queue_op(KIND_CLOSE, '0, '0, '0, 1'b0, 8'd9);                     // free slot, harmless
    queue_op(KIND_SPARE_LO, '1, '1, '1, 1'b1, 8'd1);
    queue_op(KIND_SPARE_MID, '1, '1, '1, 1'b1, 8'd1);
    queue_op(KIND_SPARE_HI, '1, '1, '1, 1'b1, 8'd1);
    queue_op(KIND_DELIVER, 32'h0000_0001, 32'h8000_0000, '0, 1'b0, 8'd0); // mode misses mask

    // random part, each phase starts from an idle block with a new mask
    run_phase(16'hFFFF, 18, 45, 10, 90, 1'b1);    // fills up, table full seen
    run_phase(16'h0000, 0, 25, 20, 100, 1'b1);    // nothing can fire
    run_phase(16'($urandom), 0, 15, 40, 100, 1'b1); // drains the table
    run_phase(16'h0001, 0, 25, 20, 110, 1'b1);
    run_phase(16'h8000, 0, 45, 10, 110, 1'b1);
    run_phase(16'($urandom), 0, 25, 20, 110, 1'b0); // last stretch at full rate

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (table_answer_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", table_answer_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
